FILE: src/sfx_pkg.sv
// shared types, codes and constants of the sound effect stream player
package sfx_pkg;

    localparam int SLOT_COUNT  = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_START = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        KIND_REG        = 3'd0,
        KIND_WAVE       = 3'd1,
        KIND_MUTE       = 3'd2,
        KIND_RESET_WAVE = 3'd3,
        KIND_DONE       = 3'd4,
        KIND_REQ        = 3'd5,
        KIND_ERR        = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        PH_NONE  = 3'd0,
        PH_HEAD  = 3'd1,
        PH_ENTRY = 3'd2,
        PH_REGS  = 3'd3,
        PH_WAVE  = 3'd4
    } phase_t;

    // job classes handed from the front to the back
    typedef enum logic [2:0] {
        OP_ERR        = 3'd0,
        OP_TICK       = 3'd1,
        OP_END        = 3'd2,
        OP_WAVE_START = 3'd3,
        OP_REG        = 3'd4,
        OP_WAVE_BYTE  = 3'd5,
        OP_START      = 3'd6
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [SLOT_COUNT-1:0] slots;   // which template words are emitted
        logic [7:0]            data;
        logic [7:0]            data2;
        logic [5:0]            addr;
        logic [3:0]            idx;
    } desc_t;

    localparam logic [2:0] TGT_FIRST_WAVE = 3'd5;
    localparam logic [2:0] TGT_WAVE_CH3   = 3'd6;
    localparam logic [2:0] TGT_END        = 3'd7;

    localparam logic [5:0] REG_BASE   = 6'h10;
    localparam logic [5:0] REG_STRIDE = 6'd5;
    localparam logic [5:0] REG_ROUTE  = 6'h25;
    localparam logic [5:0] REG_CH1_ENV = 6'h12;
    localparam logic [5:0] REG_CH1_HI  = 6'h14;
    localparam logic [5:0] REG_CH2_ENV = 6'h17;
    localparam logic [5:0] REG_CH2_HI  = 6'h19;
    localparam logic [5:0] REG_CH3_ON  = 6'h1A;
    localparam logic [5:0] REG_CH3_LEN = 6'h1B;
    localparam logic [5:0] REG_CH3_LVL = 6'h1C;
    localparam logic [5:0] REG_CH3_LO  = 6'h1D;
    localparam logic [5:0] REG_CH3_HI  = 6'h1E;
    localparam logic [5:0] REG_CH4_ENV = 6'h21;
    localparam logic [5:0] REG_CH4_CTL = 6'h23;

    localparam logic [7:0] ROUTE_WAVE_MASK = 8'hBB;
    localparam logic [7:0] ROUTE_ALL       = 8'hFF;
    localparam logic [7:0] VAL_RESTART     = 8'hC0;
    localparam logic [7:0] VAL_CH3_ENABLE  = 8'h80;
    localparam logic [7:0] VAL_CH3_LEN     = 8'hFE;
    localparam logic [7:0] VAL_CH3_LVL     = 8'h20;
    localparam logic [7:0] VAL_CH3_HI      = 8'hC7;
    localparam logic [7:0] VAL_ZERO        = 8'h00;

    localparam logic [4:0] WAVE_LEN = 5'd16;

endpackage

FILE: src/sfx_front.sv
// front end: accepts words, keeps the player state and emits job descriptors
module sfx_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [7:0]           stream_byte,
    input  logic [7:0]           routing_now,
    input  logic [3:0]           effect_mute,
    input  logic [7:0]           effect_priority,
    input  logic                 cfg_valid,
    input  logic [3:0]           cfg_data,
    input  logic                 q_full,
    output logic                 push,
    output sfx_pkg::desc_t       push_desc
);

    typedef struct packed {
        logic [4:0] sel;
        logic [5:0] ptr;
    } align_t;

    // shift the select mask until its first register sits in the top bit
    function automatic align_t align_sel(input logic [4:0] sel_in, input logic [5:0] ptr_in);
        align_t res;
        res.sel = sel_in;
        res.ptr = ptr_in;
        for (int i = 0; i < 4; i++)
        begin
            if (res.sel != 5'd0 && !res.sel[4])
            begin
                res.sel = {res.sel[3:0], 1'b0};
                res.ptr = res.ptr + 6'd1;
            end
        end
        return res;
    endfunction

    logic                    active_reg, active_next;
    sfx_pkg::phase_t         phase_reg, phase_next;
    logic [3:0]              skip_left_reg, skip_left_next;
    logic [3:0]              entries_left_reg, entries_left_next;
    logic [2:0]              entry_target_reg, entry_target_next;
    logic [4:0]              select_bits_reg, select_bits_next;
    logic [5:0]              reg_ptr_reg, reg_ptr_next;
    logic [4:0]              wave_count_reg, wave_count_next;
    logic [7:0]              saved_routing_reg, saved_routing_next;
    logic [3:0]              borrowed_mute_reg, borrowed_mute_next;
    logic [7:0]              current_priority_reg, current_priority_next;
    logic [3:0]              told_mute_reg, told_mute_next;
    logic [3:0]              global_mute_reg;

    logic                    accept;
    logic [2:0]              tgt;
    align_t                  entry_al;
    align_t                  regs_al;
    logic [3:0]              entries_dec;
    logic [4:0]              wave_inc;
    logic                    wave_full;
    logic [3:0]              want_mute;
    logic                    refused;

    assign in_ready    = !q_full;
    assign accept      = in_valid && in_ready;
    assign tgt         = stream_byte[2:0];
    assign entry_al    = align_sel(stream_byte[7:3], sfx_pkg::REG_BASE + {3'd0, tgt} * sfx_pkg::REG_STRIDE);
    assign regs_al     = align_sel({select_bits_reg[3:0], 1'b0}, reg_ptr_reg + 6'd1);
    assign entries_dec = (entries_left_reg == 4'd0) ? 4'd0 : entries_left_reg - 4'd1;
    assign wave_inc    = wave_count_reg + 5'd1;
    assign wave_full   = wave_inc >= sfx_pkg::WAVE_LEN;
    assign want_mute   = global_mute_reg | borrowed_mute_reg;
    assign refused     = effect_priority < current_priority_reg;

    // state update
    always_comb
    begin
        active_next           = active_reg;
        phase_next            = phase_reg;
        skip_left_next        = skip_left_reg;
        entries_left_next     = entries_left_reg;
        entry_target_next     = entry_target_reg;
        select_bits_next      = select_bits_reg;
        reg_ptr_next          = reg_ptr_reg;
        wave_count_next       = wave_count_reg;
        saved_routing_next    = saved_routing_reg;
        borrowed_mute_next    = borrowed_mute_reg;
        current_priority_next = current_priority_reg;
        told_mute_next        = told_mute_reg;
        if (accept)
        begin
            case (action)
                sfx_pkg::ACT_TICK:
                begin
                    if (active_reg)
                    begin
                        told_mute_next = want_mute;
                        if (phase_reg == sfx_pkg::PH_NONE)
                        begin
                            if (skip_left_reg != 4'd0)
                                skip_left_next = skip_left_reg - 4'd1;
                            else
                                phase_next = sfx_pkg::PH_HEAD;
                        end
                    end
                end
                sfx_pkg::ACT_BYTE:
                begin
                    if (active_reg)
                    begin
                        case (phase_reg)
                            sfx_pkg::PH_HEAD:
                            begin
                                skip_left_next    = stream_byte[7:4];
                                entries_left_next = stream_byte[3:0];
                                phase_next = (stream_byte[3:0] != 4'd0) ? sfx_pkg::PH_ENTRY
                                                                        : sfx_pkg::PH_NONE;
                            end
                            sfx_pkg::PH_ENTRY:
                            begin
                                entry_target_next = tgt;
                                if (tgt < sfx_pkg::TGT_FIRST_WAVE)
                                begin
                                    select_bits_next = entry_al.sel;
                                    reg_ptr_next     = entry_al.ptr;
                                    if (entry_al.sel != 5'd0)
                                        phase_next = sfx_pkg::PH_REGS;
                                    else
                                    begin
                                        entries_left_next = entries_dec;
                                        phase_next = (entries_dec != 4'd0) ? sfx_pkg::PH_ENTRY
                                                                           : sfx_pkg::PH_NONE;
                                    end
                                end
                                else if (tgt == sfx_pkg::TGT_END)
                                begin
                                    told_mute_next        = global_mute_reg;
                                    borrowed_mute_next    = 4'd0;
                                    current_priority_next = 8'd0;
                                    active_next           = 1'b0;
                                    phase_next            = sfx_pkg::PH_NONE;
                                    skip_left_next        = 4'd0;
                                    entries_left_next     = 4'd0;
                                end
                                else
                                begin
                                    saved_routing_next = routing_now;
                                    wave_count_next    = 5'd0;
                                    phase_next         = sfx_pkg::PH_WAVE;
                                end
                            end
                            sfx_pkg::PH_REGS:
                            begin
                                select_bits_next = regs_al.sel;
                                reg_ptr_next     = regs_al.ptr;
                                if (regs_al.sel == 5'd0)
                                begin
                                    entries_left_next = entries_dec;
                                    phase_next = (entries_dec != 4'd0) ? sfx_pkg::PH_ENTRY
                                                                       : sfx_pkg::PH_NONE;
                                end
                            end
                            sfx_pkg::PH_WAVE:
                            begin
                                wave_count_next = wave_inc;
                                if (wave_full)
                                begin
                                    wave_count_next   = 5'd0;
                                    entries_left_next = entries_dec;
                                    phase_next = (entries_dec != 4'd0) ? sfx_pkg::PH_ENTRY
                                                                       : sfx_pkg::PH_NONE;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                sfx_pkg::ACT_START:
                begin
                    if (!refused)
                    begin
                        current_priority_next = effect_priority;
                        borrowed_mute_next    = effect_mute;
                        skip_left_next        = 4'd0;
                        entries_left_next     = 4'd0;
                        select_bits_next      = 5'd0;
                        wave_count_next       = 5'd0;
                        phase_next            = sfx_pkg::PH_NONE;
                        active_next           = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // descriptor of the words this item causes
    always_comb
    begin
        push_desc = '0;
        case (action)
            sfx_pkg::ACT_TICK:
            begin
                push_desc.op   = sfx_pkg::OP_TICK;
                push_desc.data = {4'd0, want_mute};
                if (active_reg)
                begin
                    push_desc.slots[0] = (told_mute_reg != want_mute);
                    push_desc.slots[1] = (phase_reg == sfx_pkg::PH_NONE)
                                      && (skip_left_reg == 4'd0);
                end
            end
            sfx_pkg::ACT_BYTE:
            begin
                push_desc.op       = sfx_pkg::OP_ERR;
                push_desc.slots[0] = 1'b1;
                if (active_reg)
                begin
                    case (phase_reg)
                        sfx_pkg::PH_HEAD:
                            push_desc.slots = '0;
                        sfx_pkg::PH_ENTRY:
                        begin
                            if (tgt < sfx_pkg::TGT_FIRST_WAVE)
                                push_desc.slots = '0;
                            else if (tgt == sfx_pkg::TGT_END)
                            begin
                                push_desc.op    = sfx_pkg::OP_END;
                                push_desc.data  = {4'd0, global_mute_reg};
                                push_desc.slots = 8'b0000_0111;
                            end
                            else
                            begin
                                push_desc.op    = sfx_pkg::OP_WAVE_START;
                                push_desc.data  = routing_now;
                                push_desc.slots = 8'b0000_0011;
                            end
                        end
                        sfx_pkg::PH_REGS:
                        begin
                            push_desc.op    = sfx_pkg::OP_REG;
                            push_desc.addr  = reg_ptr_reg;
                            push_desc.data  = stream_byte;
                            push_desc.slots = 8'b0000_0001;
                        end
                        sfx_pkg::PH_WAVE:
                        begin
                            push_desc.op       = sfx_pkg::OP_WAVE_BYTE;
                            push_desc.data     = stream_byte;
                            push_desc.data2    = saved_routing_reg;
                            push_desc.idx      = wave_count_reg[3:0];
                            push_desc.slots[0] = 1'b1;
                            push_desc.slots[5:1] = {5{wave_full
                                && (entry_target_reg == sfx_pkg::TGT_WAVE_CH3)}};
                            push_desc.slots[6] = wave_full;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            sfx_pkg::ACT_START:
            begin
                if (refused)
                begin
                    push_desc.op       = sfx_pkg::OP_ERR;
                    push_desc.slots[0] = 1'b1;
                end
                else
                begin
                    push_desc.op    = sfx_pkg::OP_START;
                    // cut words for the channels the old effect held
                    push_desc.slots = {1'b1, {2{borrowed_mute_reg[3]}}, borrowed_mute_reg[2],
                                       {2{borrowed_mute_reg[1]}}, {2{borrowed_mute_reg[0]}}};
                end
            end
            default:
            begin
                push_desc.op       = sfx_pkg::OP_ERR;
                push_desc.slots[0] = 1'b1;
            end
        endcase
    end

    assign push = accept && (push_desc.slots != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg           <= 1'b0;
            phase_reg            <= sfx_pkg::PH_NONE;
            skip_left_reg        <= 4'd0;
            entries_left_reg     <= 4'd0;
            entry_target_reg     <= 3'd0;
            select_bits_reg      <= 5'd0;
            reg_ptr_reg          <= 6'd0;
            wave_count_reg       <= 5'd0;
            saved_routing_reg    <= 8'd0;
            borrowed_mute_reg    <= 4'd0;
            current_priority_reg <= 8'd0;
            told_mute_reg        <= 4'd0;
            global_mute_reg      <= 4'd0;
        end
        else
        begin
            active_reg           <= active_next;
            phase_reg            <= phase_next;
            skip_left_reg        <= skip_left_next;
            entries_left_reg     <= entries_left_next;
            entry_target_reg     <= entry_target_next;
            select_bits_reg      <= select_bits_next;
            reg_ptr_reg          <= reg_ptr_next;
            wave_count_reg       <= wave_count_next;
            saved_routing_reg    <= saved_routing_next;
            borrowed_mute_reg    <= borrowed_mute_next;
            current_priority_reg <= current_priority_next;
            told_mute_reg        <= told_mute_next;
            if (cfg_valid)
                global_mute_reg <= cfg_data;
        end
    end

endmodule

FILE: src/sfx_queue.sv
// short descriptor queue between the front and the back
module sfx_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sfx_pkg::desc_t push_desc,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output sfx_pkg::desc_t head_desc
);

    localparam int PtrW = (sfx_pkg::QUEUE_DEPTH > 1) ? $clog2(sfx_pkg::QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(sfx_pkg::QUEUE_DEPTH + 1);

    sfx_pkg::desc_t  slot_q [sfx_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CntW'(sfx_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = slot_q[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(sfx_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(sfx_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_q[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: src/sfx_back.sv
// back end: expands each descriptor into result words, one per cycle unless the output stalls
module sfx_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           head_valid,
    input  sfx_pkg::desc_t head_desc,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [2:0]     out_kind,
    output logic [5:0]     out_addr,
    output logic [7:0]     out_value,
    output logic [3:0]     out_idx,
    output logic           out_last
);

    typedef struct packed {
        sfx_pkg::kind_t kind;
        logic [5:0]     addr;
        logic [7:0]     value;
        logic [3:0]     idx;
    } word_t;

    function automatic word_t make_word(input sfx_pkg::kind_t k, input logic [5:0] a,
                                        input logic [7:0] v);
        word_t w;
        w.kind  = k;
        w.addr  = a;
        w.value = v;
        w.idx   = 4'd0;
        return w;
    endfunction

    // template word number slot of a descriptor
    function automatic word_t slot_word(input sfx_pkg::desc_t d, input logic [2:0] slot);
        word_t w;
        w = make_word(sfx_pkg::KIND_ERR, 6'd0, sfx_pkg::VAL_ZERO);
        case (d.op)
            sfx_pkg::OP_TICK:
                w = (slot == 3'd0) ? make_word(sfx_pkg::KIND_MUTE, 6'd0, d.data)
                                   : make_word(sfx_pkg::KIND_REQ, 6'd0, sfx_pkg::VAL_ZERO);
            sfx_pkg::OP_END:
            begin
                case (slot)
                    3'd0:    w = make_word(sfx_pkg::KIND_MUTE, 6'd0, d.data);
                    3'd1:    w = make_word(sfx_pkg::KIND_RESET_WAVE, 6'd0, sfx_pkg::VAL_ZERO);
                    default: w = make_word(sfx_pkg::KIND_DONE, 6'd0, sfx_pkg::VAL_ZERO);
                endcase
            end
            sfx_pkg::OP_WAVE_START:
                w = (slot == 3'd0)
                    ? make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_ROUTE,
                                d.data & sfx_pkg::ROUTE_WAVE_MASK)
                    : make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_ON, sfx_pkg::VAL_ZERO);
            sfx_pkg::OP_REG:
                w = make_word(sfx_pkg::KIND_REG, d.addr, d.data);
            sfx_pkg::OP_WAVE_BYTE:
            begin
                case (slot)
                    3'd0:
                    begin
                        w     = make_word(sfx_pkg::KIND_WAVE, 6'd0, d.data);
                        w.idx = d.idx;
                    end
                    3'd1: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_ON,
                                        sfx_pkg::VAL_CH3_ENABLE);
                    3'd2: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_LEN,
                                        sfx_pkg::VAL_CH3_LEN);
                    3'd3: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_LVL,
                                        sfx_pkg::VAL_CH3_LVL);
                    3'd4: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_LO,
                                        sfx_pkg::VAL_ZERO);
                    3'd5: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_HI,
                                        sfx_pkg::VAL_CH3_HI);
                    default: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_ROUTE, d.data2);
                endcase
            end
            sfx_pkg::OP_START:
            begin
                case (slot)
                    3'd0: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH1_ENV, sfx_pkg::VAL_ZERO);
                    3'd1: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH1_HI, sfx_pkg::VAL_RESTART);
                    3'd2: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH2_ENV, sfx_pkg::VAL_ZERO);
                    3'd3: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH2_HI, sfx_pkg::VAL_RESTART);
                    3'd4: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_LVL, sfx_pkg::VAL_ZERO);
                    3'd5: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH4_ENV, sfx_pkg::VAL_ZERO);
                    3'd6: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_CH4_CTL, sfx_pkg::VAL_RESTART);
                    default: w = make_word(sfx_pkg::KIND_REG, sfx_pkg::REG_ROUTE, sfx_pkg::ROUTE_ALL);
                endcase
            end
            default:
                w = make_word(sfx_pkg::KIND_ERR, 6'd0, sfx_pkg::VAL_ZERO);
        endcase
        return w;
    endfunction

    sfx_pkg::desc_t                 cur_reg, cur_next;
    logic [sfx_pkg::SLOT_COUNT-1:0] slots_reg, slots_next;
    logic                           out_valid_reg, out_valid_next;
    word_t                          word_reg, word_next;
    logic                           last_reg, last_next;

    logic [sfx_pkg::SLOT_COUNT-1:0] remaining;
    logic [2:0]                     slot_sel;
    logic                           emit;
    word_t                          cur_word;

    // lowest pending slot goes out first
    always_comb
    begin
        slot_sel = 3'd0;
        for (int i = sfx_pkg::SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (slots_reg[i])
                slot_sel = 3'(i);
        end
    end

    assign remaining = slots_reg & (slots_reg - 1'b1);
    assign emit      = (slots_reg != '0) && (!out_valid_reg || out_ready);
    assign pop       = head_valid && ((slots_reg == '0) || (emit && remaining == '0));
    assign cur_word  = slot_word(cur_reg, slot_sel);

    always_comb
    begin
        cur_next       = cur_reg;
        slots_next     = slots_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        if (emit)
        begin
            slots_next     = remaining;
            out_valid_next = 1'b1;
            word_next      = cur_word;
            last_next      = (remaining == '0);
        end
        else if (out_ready)
            out_valid_next = 1'b0;
        if (pop)
        begin
            cur_next   = head_desc;
            slots_next = head_desc.slots;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slots_reg     <= slots_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        word_reg <= word_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = word_reg.kind;
    assign out_addr  = word_reg.addr;
    assign out_value = word_reg.value;
    assign out_idx   = word_reg.idx;
    assign out_last  = last_reg;

endmodule

FILE: src/sound_effect_stream_player.sv
// sound effect stream player top level
// an item's first result word passes the queue, then the descriptor and output registers
// throughput: one input word per cycle while the 2-entry descriptor queue has room
// output: one word per cycle unless stalled, 0 to 8 words per item as the front end sets
// reset: rst_n clears all player state, global_mute, the queue and the output valid flag
module sound_effect_stream_player (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // stream_byte, routing_now, effect_mute, effect_priority
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // reg_address, value, wave_index
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data   // global_mute
);

    logic           push;
    sfx_pkg::desc_t push_desc;
    logic           q_full;
    logic           pop;
    logic           head_valid;
    sfx_pkg::desc_t head_desc;
    logic [5:0]     out_addr;
    logic [7:0]     out_value;
    logic [3:0]     out_idx;

    assign cfg_ready = 1'b1;

    sfx_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .action          (s_tuser),
        .stream_byte     (s_tdata[7:0]),
        .routing_now     (s_tdata[15:8]),
        .effect_mute     (s_tdata[19:16]),
        .effect_priority (s_tdata[27:20]),
        .cfg_valid       (cfg_valid),
        .cfg_data        (cfg_data),
        .q_full          (q_full),
        .push            (push),
        .push_desc       (push_desc)
    );

    sfx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    sfx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (m_tuser),
        .out_addr   (out_addr),
        .out_value  (out_value),
        .out_idx    (out_idx),
        .out_last   (m_tlast)
    );

    assign m_tdata = {6'd0, out_idx, out_value, out_addr};

endmodule

FILE: src/sfx_checker.sv
// port level checks for the sound effect stream player and their bind
module sfx_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser != 3'd7)
        else $error("undefined result kind");

    a_addr_only_reg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != sfx_pkg::KIND_REG |-> m_tdata[5:0] == 6'd0)
        else $error("register address on a non register word");

    a_idx_only_wave: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != sfx_pkg::KIND_WAVE |-> m_tdata[17:14] == 4'd0)
        else $error("wave index on a non wave word");

    // done and error always close the words of their item
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == sfx_pkg::KIND_DONE || m_tuser == sfx_pkg::KIND_ERR) |-> m_tlast)
        else $error("done or error word not marked last");

endmodule

bind sound_effect_stream_player sfx_checker u_sfx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: tb/sv/tb_sound_effect_stream_player.sv
// testbench for the sound effect stream player: directed table, then state-driven random words
`timescale 1ns / 1ps

module tb_sound_effect_stream_player;

    localparam logic [1:0] ACT_BAD     = 2'd3;
    localparam int         STALL_LIMIT = 4000;
    localparam int         SETTLE      = 20;
    localparam int         IDLE_PCT    = 38;
    localparam int         RAND_ITEMS  = 26;

    typedef struct packed {
        logic [1:0] act;
        logic [7:0] sbyte;
        logic [7:0] route;
        logic [3:0] emute;
        logic [7:0] eprio;
    } item_t;

    typedef struct packed {
        sfx_pkg::kind_t kind;
        logic [5:0]     addr;
        logic [7:0]     value;
        logic [3:0]     idx;
        logic           last;
    } word_t;

    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_NONE    = 2'd1,
        ROW_ONE     = 2'd2
    } row_mode_t;

    typedef struct packed {
        logic [1:0]     act;
        logic [7:0]     sbyte;
        logic [7:0]     route;
        logic [3:0]     emute;
        logic [7:0]     eprio;
        row_mode_t      mode;
        sfx_pkg::kind_t kind;
        logic [5:0]     addr;
        logic [7:0]     value;
    } step_row_t;

    // action, byte, routing, mute, priority, how checked, typed word (kind, addr, value)
    localparam step_row_t DIRECTED [0:24] = '{
        '{sfx_pkg::ACT_TICK,  8'h00, 8'h00, 4'h0, 8'h00, ROW_NONE,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'hFF, 8'hFF, 4'h0, 8'h00, ROW_ONE,
          sfx_pkg::KIND_ERR, 6'h00, 8'h00},
        '{ACT_BAD,            8'h00, 8'h00, 4'h0, 8'h00, ROW_ONE,
          sfx_pkg::KIND_ERR, 6'h00, 8'h00},
        '{sfx_pkg::ACT_START, 8'h00, 8'h00, 4'hF, 8'h10, ROW_ONE,
          sfx_pkg::KIND_REG, sfx_pkg::REG_ROUTE, sfx_pkg::ROUTE_ALL},
        '{sfx_pkg::ACT_START, 8'h00, 8'h00, 4'h5, 8'h05, ROW_ONE,
          sfx_pkg::KIND_ERR, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h00, 8'h00, 4'h0, 8'h00, ROW_ONE,
          sfx_pkg::KIND_ERR, 6'h00, 8'h00},
        '{sfx_pkg::ACT_TICK,  8'h00, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h25, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'hF8, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h00, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'hFF, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h5A, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'hA5, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h01, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_TICK,  8'h00, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h02, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h0C, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h77, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h07, 8'hFF, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_TICK,  8'h00, 8'h00, 4'h0, 8'h00, ROW_NONE,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_START, 8'h00, 8'h00, 4'hF, 8'h00, ROW_ONE,
          sfx_pkg::KIND_REG, sfx_pkg::REG_ROUTE, sfx_pkg::ROUTE_ALL},
        '{sfx_pkg::ACT_START, 8'h00, 8'h00, 4'h0, 8'hFF, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_START, 8'h00, 8'h00, 4'h3, 8'hFE, ROW_ONE,
          sfx_pkg::KIND_ERR, 6'h00, 8'h00},
        '{sfx_pkg::ACT_TICK,  8'h00, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00},
        '{sfx_pkg::ACT_BYTE,  8'h10, 8'h00, 4'h0, 8'h00, ROW_PREDICT,
          sfx_pkg::KIND_REG, 6'h00, 8'h00}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    bit calm = 1'b0;
    int errors = 0;
    int quiet_cycles = 0;

    word_t step_words[$];
    word_t sfx_words_due[$];

    // player state as the predictor sees it
    logic            pl_active;
    sfx_pkg::phase_t pl_phase;
    logic [3:0]      pl_skip;
    logic [3:0]      pl_entries;
    logic [2:0]      pl_target;
    logic [4:0]      pl_select;
    logic [5:0]      pl_next_reg;
    logic [4:0]      pl_wave_cnt;
    logic [7:0]      pl_saved_route;
    logic [3:0]      pl_borrowed;
    logic [7:0]      pl_prio;
    logic [3:0]      pl_told;
    logic [3:0]      pl_global;

    sound_effect_stream_player u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic emit(input sfx_pkg::kind_t k, input logic [5:0] a, input logic [7:0] v,
                        input logic [3:0] i);
        word_t w;
        w.kind  = k;
        w.addr  = a;
        w.value = v;
        w.idx   = i;
        w.last  = 1'b0;
        step_words.push_back(w);
    endtask

    task automatic close_entry();
        if (pl_entries != 4'd0)
            pl_entries = pl_entries - 4'd1;
        pl_phase = (pl_entries != 4'd0) ? sfx_pkg::PH_ENTRY : sfx_pkg::PH_NONE;
    endtask

    // move to the first register whose select bit is set
    task automatic skip_unselected();
        while (pl_select != 5'd0 && !pl_select[4])
        begin
            pl_select   = pl_select << 1;
            pl_next_reg = pl_next_reg + 6'd1;
        end
    endtask

    task automatic take_stream_byte(input logic [7:0] b, input logic [7:0] route);
        if (!pl_active)
        begin
            emit(sfx_pkg::KIND_ERR, 6'd0, 8'd0, 4'd0);
            return;
        end
        case (pl_phase)
            sfx_pkg::PH_HEAD:
            begin
                pl_skip    = b[7:4];
                pl_entries = b[3:0];
                pl_phase   = (pl_entries != 4'd0) ? sfx_pkg::PH_ENTRY : sfx_pkg::PH_NONE;
            end
            sfx_pkg::PH_ENTRY:
            begin
                pl_target = b[2:0];
                if (pl_target < sfx_pkg::TGT_FIRST_WAVE)
                begin
                    pl_select   = b[7:3];
                    pl_next_reg = sfx_pkg::REG_BASE + sfx_pkg::REG_STRIDE * {3'd0, pl_target};
                    skip_unselected();
                    if (pl_select != 5'd0)
                        pl_phase = sfx_pkg::PH_REGS;
                    else
                        close_entry();
                end
                else if (pl_target == sfx_pkg::TGT_END)
                begin
                    emit(sfx_pkg::KIND_MUTE, 6'd0, {4'd0, pl_global}, 4'd0);
                    emit(sfx_pkg::KIND_RESET_WAVE, 6'd0, 8'd0, 4'd0);
                    emit(sfx_pkg::KIND_DONE, 6'd0, 8'd0, 4'd0);
                    pl_told     = pl_global;
                    pl_borrowed = 4'd0;
                    pl_prio     = 8'd0;
                    pl_active   = 1'b0;
                    pl_phase    = sfx_pkg::PH_NONE;
                    pl_skip     = 4'd0;
                    pl_entries  = 4'd0;
                end
                else
                begin
                    pl_saved_route = route;
                    emit(sfx_pkg::KIND_REG, sfx_pkg::REG_ROUTE,
                         route & sfx_pkg::ROUTE_WAVE_MASK, 4'd0);
                    emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_ON, sfx_pkg::VAL_ZERO, 4'd0);
                    pl_wave_cnt = 5'd0;
                    pl_phase    = sfx_pkg::PH_WAVE;
                end
            end
            sfx_pkg::PH_REGS:
            begin
                emit(sfx_pkg::KIND_REG, pl_next_reg, b, 4'd0);
                pl_select   = pl_select << 1;
                pl_next_reg = pl_next_reg + 6'd1;
                skip_unselected();
                if (pl_select == 5'd0)
                    close_entry();
            end
            sfx_pkg::PH_WAVE:
            begin
                emit(sfx_pkg::KIND_WAVE, 6'd0, b, pl_wave_cnt[3:0]);
                pl_wave_cnt = pl_wave_cnt + 5'd1;
                if (pl_wave_cnt >= sfx_pkg::WAVE_LEN)
                begin
                    if (pl_target == sfx_pkg::TGT_WAVE_CH3)
                    begin
                        emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_ON,
                             sfx_pkg::VAL_CH3_ENABLE, 4'd0);
                        emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_LEN,
                             sfx_pkg::VAL_CH3_LEN, 4'd0);
                        emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_LVL,
                             sfx_pkg::VAL_CH3_LVL, 4'd0);
                        emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_LO,
                             sfx_pkg::VAL_ZERO, 4'd0);
                        emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_HI,
                             sfx_pkg::VAL_CH3_HI, 4'd0);
                    end
                    emit(sfx_pkg::KIND_REG, sfx_pkg::REG_ROUTE, pl_saved_route, 4'd0);
                    pl_wave_cnt = 5'd0;
                    close_entry();
                end
            end
            default:
                emit(sfx_pkg::KIND_ERR, 6'd0, 8'd0, 4'd0);
        endcase
    endtask

    task automatic take_start(input logic [3:0] mute, input logic [7:0] prio);
        if (prio < pl_prio)
        begin
            emit(sfx_pkg::KIND_ERR, 6'd0, 8'd0, 4'd0);
            return;
        end
        pl_prio = prio;
        // silence what the replaced effect borrowed
        if (pl_borrowed[0])
        begin
            emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH1_ENV, sfx_pkg::VAL_ZERO, 4'd0);
            emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH1_HI, sfx_pkg::VAL_RESTART, 4'd0);
        end
        if (pl_borrowed[1])
        begin
            emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH2_ENV, sfx_pkg::VAL_ZERO, 4'd0);
            emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH2_HI, sfx_pkg::VAL_RESTART, 4'd0);
        end
        if (pl_borrowed[2])
            emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH3_LVL, sfx_pkg::VAL_ZERO, 4'd0);
        if (pl_borrowed[3])
        begin
            emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH4_ENV, sfx_pkg::VAL_ZERO, 4'd0);
            emit(sfx_pkg::KIND_REG, sfx_pkg::REG_CH4_CTL, sfx_pkg::VAL_RESTART, 4'd0);
        end
        emit(sfx_pkg::KIND_REG, sfx_pkg::REG_ROUTE, sfx_pkg::ROUTE_ALL, 4'd0);
        pl_borrowed = mute;
        pl_skip     = 4'd0;
        pl_entries  = 4'd0;
        pl_select   = 5'd0;
        pl_wave_cnt = 5'd0;
        pl_phase    = sfx_pkg::PH_NONE;
        pl_active   = 1'b1;
    endtask

    task automatic take_tick();
        logic [3:0] want;
        if (!pl_active)
            return;
        want = pl_global | pl_borrowed;
        if (pl_told != want)
        begin
            emit(sfx_pkg::KIND_MUTE, 6'd0, {4'd0, want}, 4'd0);
            pl_told = want;
        end
        if (pl_phase != sfx_pkg::PH_NONE)
            return;
        if (pl_skip != 4'd0)
            pl_skip = pl_skip - 4'd1;
        else
        begin
            emit(sfx_pkg::KIND_REQ, 6'd0, 8'd0, 4'd0);
            pl_phase = sfx_pkg::PH_HEAD;
        end
    endtask

    // leaves the words one item causes in step_words, last flag set
    task automatic player_step(input item_t it);
        step_words.delete();
        case (it.act)
            sfx_pkg::ACT_TICK:  take_tick();
            sfx_pkg::ACT_BYTE:  take_stream_byte(it.sbyte, it.route);
            sfx_pkg::ACT_START: take_start(it.emute, it.eprio);
            default:            emit(sfx_pkg::KIND_ERR, 6'd0, 8'd0, 4'd0);
        endcase
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
    endtask

    task automatic send_word(input item_t it);
        @(negedge clk);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, it.eprio, it.emute, it.route, it.sbyte};
        s_tuser  <= it.act;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic play_predicted(input item_t it);
        player_step(it);
        foreach (step_words[i])
            sfx_words_due.push_back(step_words[i]);
        send_word(it);
    endtask

    task automatic play_row(input step_row_t row);
        item_t it;
        word_t w;
        it.act   = row.act;
        it.sbyte = row.sbyte;
        it.route = row.route;
        it.emute = row.emute;
        it.eprio = row.eprio;
        if (row.mode == ROW_PREDICT)
            play_predicted(it);
        else
        begin
            player_step(it);
            if (row.mode == ROW_ONE)
            begin
                w.kind  = row.kind;
                w.addr  = row.addr;
                w.value = row.value;
                w.idx   = 4'd0;
                w.last  = 1'b1;
                sfx_words_due.push_back(w);
            end
            send_word(it);
        end
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sfx_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_global_mute(input logic [3:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        pl_global = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly well-formed effect streams chosen from the predicted state, some noise
    function automatic item_t pick_item();
        item_t it;
        int    r;
        int    t;
        it.act   = sfx_pkg::ACT_TICK;
        it.sbyte = 8'($urandom_range(255));
        it.route = 8'($urandom_range(255));
        it.emute = 4'($urandom_range(15));
        it.eprio = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 12)
            it.act = 2'($urandom_range(2));
        else if (!pl_active)
            it.act = sfx_pkg::ACT_START;
        else
        begin
            case (pl_phase)
                sfx_pkg::PH_NONE:
                begin
                    if (r < 20)
                    begin
                        it.act   = sfx_pkg::ACT_START;
                        it.eprio = 8'($urandom_range(255, pl_prio));
                    end
                    else
                        it.act = sfx_pkg::ACT_TICK;
                end
                sfx_pkg::PH_HEAD:
                begin
                    it.act = sfx_pkg::ACT_BYTE;
                    if (r >= 25)
                        it.sbyte = {4'($urandom_range(2)), 4'($urandom_range(4))};
                end
                sfx_pkg::PH_ENTRY:
                begin
                    it.act = sfx_pkg::ACT_BYTE;
                    t = $urandom_range(99);
                    if (t < 55)
                        it.sbyte[2:0] = 3'($urandom_range(4));
                    else if (t < 85)
                        it.sbyte[2:0] = (t < 70) ? sfx_pkg::TGT_FIRST_WAVE
                                                 : sfx_pkg::TGT_WAVE_CH3;
                    else
                        it.sbyte[2:0] = sfx_pkg::TGT_END;
                end
                default:
                    it.act = (r < 20) ? sfx_pkg::ACT_TICK : sfx_pkg::ACT_BYTE;
            endcase
        end
        return it;
    endfunction

    always @(negedge clk)
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        word_t got;
        word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind  = sfx_pkg::kind_t'(m_tuser);
            got.addr  = m_tdata[5:0];
            got.value = m_tdata[13:6];
            got.idx   = m_tdata[17:14];
            got.last  = m_tlast;
            if (sfx_words_due.size() == 0)
            begin
                $display("%0t: unexpected word kind=%0d addr=%h value=%h idx=%0d last=%b",
                         $time, got.kind, got.addr, got.value, got.idx, got.last);
                errors++;
            end
            else
            begin
                want = sfx_words_due.pop_front();
                if (got.kind !== want.kind || got.addr !== want.addr ||
                    got.value !== want.value || got.idx !== want.idx ||
                    got.last !== want.last)
                begin
                    $display("%0t: expected kind=%0d addr=%h value=%h idx=%0d last=%b",
                             $time, want.kind, want.addr, want.value, want.idx, want.last);
                    $display("%0t: actual   kind=%0d addr=%h value=%h idx=%0d last=%b",
                             $time, got.kind, got.addr, got.value, got.idx, got.last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_sound_effect_stream_player NOT OK");
            $finish;
        end
    end

    initial
    begin
        item_t      it;
        logic [3:0] gm;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 32'd0;
        s_tuser   = 2'd0;
        cfg_valid = 1'b0;
        cfg_data  = 4'd0;
        pl_active      = 1'b0;
        pl_phase       = sfx_pkg::PH_NONE;
        pl_skip        = 4'd0;
        pl_entries     = 4'd0;
        pl_target      = 3'd0;
        pl_select      = 5'd0;
        pl_next_reg    = 6'd0;
        pl_wave_cnt    = 5'd0;
        pl_saved_route = 8'd0;
        pl_borrowed    = 4'd0;
        pl_prio        = 8'd0;
        pl_told        = 4'd0;
        pl_global      = 4'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_global_mute(4'h0);
        for (int i = 0; i < $size(DIRECTED); i++)
            play_row(DIRECTED[i]);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       gm = 4'hF;
                1:       gm = 4'($urandom_range(15));
                2:       gm = 4'h0;
                default: gm = 4'($urandom_range(15));
            endcase
            write_global_mute(gm);
            calm = (p == 2);
            repeat (RAND_ITEMS)
            begin
                it = pick_item();
                play_predicted(it);
            end
            settle();
        end

        if (errors == 0)
            $display("tb_sound_effect_stream_player OK");
        else
            $display("tb_sound_effect_stream_player NOT OK");
        $finish;
    end

endmodule

FILE: sound_effect_stream_player.f
src/sfx_pkg.sv
src/sfx_front.sv
src/sfx_queue.sv
src/sfx_back.sv
src/sound_effect_stream_player.sv
src/sfx_checker.sv
tb/sv/tb_sound_effect_stream_player.sv
